/* src/capm_pkg.sv */
// shared types and constants for the complex average power meter
package capm_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int COUNT_WIDTH  = 32;
  localparam int IN_WIDTH     = 16;
  localparam int OUT_WIDTH    = 32;
  localparam int ENERGY_WIDTH = 2 * SAMPLE_WIDTH;
  localparam int SUM_WIDTH    = 64;

  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_WIDTH   = $clog2(QUEUE_DEPTH);
  localparam int QLEVEL_WIDTH = $clog2(QUEUE_DEPTH + 1);

  localparam int DIV_STEPS    = SUM_WIDTH;
  localparam int STEP_WIDTH   = $clog2(DIV_STEPS);

  localparam int ADDR_WIDTH   = 3;
  localparam int DATA_WIDTH   = 32;
  localparam int IDX_WIDTH    = ADDR_WIDTH - 2;
  localparam int REG_MEMORY_IDX = 0;

  typedef struct packed {
    logic [SUM_WIDTH-1:0]   energy;
    logic [COUNT_WIDTH-1:0] count;
    logic                   saturated;
  } div_job_t;

  typedef struct packed {
    logic     push;
    div_job_t job;
  } queue_wr_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

endpackage

/* src/capm_front.sv */
// front end: squares samples, accumulates energy and count, queues block totals
module capm_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [capm_pkg::IN_WIDTH-1:0]    sample_i,
  input  logic [capm_pkg::IN_WIDTH-1:0]    sample_q,
  input  logic                             last_in_block,
  input  logic                             memory_across_blocks,
  input  logic [capm_pkg::QLEVEL_WIDTH-1:0] queue_level,
  output capm_pkg::queue_wr_t              queue_wr
);
  import capm_pkg::*;

  logic signed [SAMPLE_WIDTH-1:0]   si;
  logic signed [SAMPLE_WIDTH-1:0]   sq;
  logic signed [ENERGY_WIDTH-1:0]   sq_i;
  logic signed [ENERGY_WIDTH-1:0]   sq_q;
  logic [ENERGY_WIDTH-1:0]          energy_in;
  logic                             in_accept;

  logic                             a_valid;
  logic                             a_last;
  logic [ENERGY_WIDTH-1:0]          a_energy;

  logic [SUM_WIDTH-1:0]             energy_sum;
  logic [COUNT_WIDTH-1:0]           sample_total;
  logic                             block_start_pending;
  logic                             saturated_flag;

  logic                             start_clear;
  logic [SUM_WIDTH-1:0]             e_base;
  logic [COUNT_WIDTH-1:0]           c_base;
  logic                             s_base;
  logic [SUM_WIDTH:0]               sum_ext;
  logic [SUM_WIDTH-1:0]             energy_sum_next;
  logic [COUNT_WIDTH-1:0]           sample_total_next;
  logic                             saturated_flag_next;

  assign si = sample_i[SAMPLE_WIDTH-1:0];
  assign sq = sample_q[SAMPLE_WIDTH-1:0];
  assign sq_i = si * si;
  assign sq_q = sq * sq;
  assign energy_in = $unsigned(sq_i) + $unsigned(sq_q);

  // hold off while a block end could find the queue full
  assign in_stall = (queue_level == QLEVEL_WIDTH'(QUEUE_DEPTH)) ||
                    ((queue_level == QLEVEL_WIDTH'(QUEUE_DEPTH - 1)) && a_valid && a_last);
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_energy <= energy_in;
      a_last   <= last_in_block;
    end
  end

  always_comb begin
    start_clear = block_start_pending && !memory_across_blocks;
    e_base = start_clear ? '0 : energy_sum;
    c_base = start_clear ? '0 : sample_total;
    s_base = start_clear ? 1'b0 : saturated_flag;
    sum_ext = {1'b0, e_base} + (SUM_WIDTH + 1)'(a_energy);
    if (c_base != '1) begin
      energy_sum_next     = sum_ext[SUM_WIDTH] ? '1 : sum_ext[SUM_WIDTH-1:0];
      sample_total_next   = c_base + COUNT_WIDTH'(1);
      saturated_flag_next = s_base;
    end else begin
      // counter full: sample dropped
      energy_sum_next     = e_base;
      sample_total_next   = c_base;
      saturated_flag_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      energy_sum          <= '0;
      sample_total        <= '0;
      block_start_pending <= 1'b1;
      saturated_flag      <= 1'b0;
    end else if (a_valid) begin
      energy_sum          <= energy_sum_next;
      sample_total        <= sample_total_next;
      block_start_pending <= a_last;
      saturated_flag      <= saturated_flag_next;
    end
  end

  assign queue_wr.push          = a_valid && a_last;
  assign queue_wr.job.energy    = energy_sum_next;
  assign queue_wr.job.count     = sample_total_next;
  assign queue_wr.job.saturated = saturated_flag_next;

endmodule

/* src/capm_queue.sv */
// short queue of block totals between the accumulator and the divider
module capm_queue (
  input  logic                              clk,
  input  logic                              rst,
  input  capm_pkg::queue_wr_t               queue_wr,
  input  logic                              pop,
  output logic                              job_valid,
  output capm_pkg::div_job_t                job,
  output logic [capm_pkg::QLEVEL_WIDTH-1:0] level
);
  import capm_pkg::*;

  div_job_t                entries [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0]   wr_ptr;
  logic [QPTR_WIDTH-1:0]   rd_ptr;

  always_ff @(posedge clk) begin
    if (queue_wr.push) begin
      entries[wr_ptr] <= queue_wr.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (queue_wr.push) begin
        wr_ptr <= (wr_ptr == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_WIDTH'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_WIDTH'(1);
      end
      if (queue_wr.push && !pop) begin
        level <= level + QLEVEL_WIDTH'(1);
      end else if (pop && !queue_wr.push) begin
        level <= level - QLEVEL_WIDTH'(1);
      end
    end
  end

  assign job_valid = (level != '0);
  assign job       = entries[rd_ptr];

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    queue_wr.push |-> (level != QLEVEL_WIDTH'(QUEUE_DEPTH)))
    else $error("block total written into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (level != '0))
    else $error("read from an empty queue");

endmodule

/* src/capm_div.sv */
// back end: bit-serial 64/32 divider and result register
module capm_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           job_valid,
  input  capm_pkg::div_job_t             job,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [capm_pkg::OUT_WIDTH-1:0] avg_power,
  output logic [capm_pkg::OUT_WIDTH-1:0] samples_counted,
  output logic                           count_saturated
);
  import capm_pkg::*;

  div_state_t              state;
  div_state_t              state_next;
  logic                    step;
  logic                    load_out;

  logic [SUM_WIDTH-1:0]    dq;
  logic [COUNT_WIDTH-1:0]  rem;
  logic [COUNT_WIDTH-1:0]  divisor;
  logic                    job_sat;
  logic [STEP_WIDTH-1:0]   step_cnt;
  logic                    last_step;

  logic [COUNT_WIDTH:0]    trial;
  logic [COUNT_WIDTH:0]    diff;
  logic                    fits;
  logic [OUT_WIDTH-1:0]    quotient;

  assign last_step = (step_cnt == STEP_WIDTH'(DIV_STEPS - 1));

  always_comb begin
    state_next = state;
    case (state)
      DIV_IDLE: if (job_valid) state_next = DIV_RUN;
      DIV_RUN:  if (last_step) state_next = DIV_DONE;
      DIV_DONE: if (!out_valid || !out_stall) state_next = DIV_IDLE;
      default:  state_next = DIV_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    step     = 1'b0;
    load_out = 1'b0;
    case (state)
      DIV_IDLE: pop = job_valid;
      DIV_RUN:  step = 1'b1;
      DIV_DONE: load_out = !out_valid || !out_stall;
      default:  pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // restoring division, one quotient bit per cycle shifted into dq
  always_comb begin
    trial = {rem, dq[SUM_WIDTH-1]};
    diff  = trial - {1'b0, divisor};
    fits  = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      dq       <= job.energy;
      rem      <= '0;
      divisor  <= job.count;
      job_sat  <= job.saturated;
      step_cnt <= '0;
    end else if (step) begin
      dq       <= {dq[SUM_WIDTH-2:0], fits};
      rem      <= fits ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
      step_cnt <= step_cnt + STEP_WIDTH'(1);
    end
  end

  always_comb begin
    if (divisor == '0) begin
      quotient = '0;
    end else if (|dq[SUM_WIDTH-1:OUT_WIDTH]) begin
      quotient = '1;
    end else begin
      quotient = dq[OUT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      avg_power       <= quotient;
      samples_counted <= OUT_WIDTH'(divisor);
      count_saturated <= job_sat;
    end
  end

  a_pop_starts: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == DIV_RUN))
    else $error("job taken without starting the divider");

  a_run_length: assert property (@(posedge clk) disable iff (rst)
    (state == DIV_RUN) && last_step |=> (state == DIV_DONE))
    else $error("divider did not finish after the last step");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> (job.count != '0))
    else $error("queued block has a zero sample count");

endmodule

/* src/complex_average_power_meter.sv */
// top level: config register, sample front end, queue and divider back end
// throughput: one sample per cycle while in_stall is low; block results are paced by
//   the 64-step bit-serial divider, with up to 4 block results queued ahead of it
// synchronous reset clears the totals, the queue and the divider, and sets memory on
module complex_average_power_meter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [capm_pkg::ADDR_WIDTH-1:0]  paddr,
  input  logic [capm_pkg::DATA_WIDTH-1:0]  pwdata,
  output logic [capm_pkg::DATA_WIDTH-1:0]  prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [capm_pkg::IN_WIDTH-1:0]    sample_i,
  input  logic [capm_pkg::IN_WIDTH-1:0]    sample_q,
  input  logic                             last_in_block,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [capm_pkg::OUT_WIDTH-1:0]   avg_power,
  output logic [capm_pkg::OUT_WIDTH-1:0]   samples_counted,
  output logic                             count_saturated
);
  import capm_pkg::*;

  logic                     memory_across_blocks;
  logic                     cfg_write;
  logic [IDX_WIDTH-1:0]     reg_idx;
  queue_wr_t                queue_wr;
  logic [QLEVEL_WIDTH-1:0]  queue_level;
  logic                     job_valid;
  div_job_t                 job;
  logic                     pop;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[ADDR_WIDTH-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      memory_across_blocks <= 1'b1;
    end else if (cfg_write && (reg_idx == IDX_WIDTH'(REG_MEMORY_IDX))) begin
      memory_across_blocks <= pwdata[0];
    end
  end

  always_comb begin
    if (reg_idx == IDX_WIDTH'(REG_MEMORY_IDX)) begin
      prdata = {{(DATA_WIDTH - 1){1'b0}}, memory_across_blocks};
    end else begin
      prdata = '0;
    end
  end

  capm_front u_front (
    .clk                  (clk),
    .rst                  (rst),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .sample_i             (sample_i),
    .sample_q             (sample_q),
    .last_in_block        (last_in_block),
    .memory_across_blocks (memory_across_blocks),
    .queue_level          (queue_level),
    .queue_wr             (queue_wr)
  );

  capm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .queue_wr  (queue_wr),
    .pop       (pop),
    .job_valid (job_valid),
    .job       (job),
    .level     (queue_level)
  );

  capm_div u_div (
    .clk             (clk),
    .rst             (rst),
    .job_valid       (job_valid),
    .job             (job),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .avg_power       (avg_power),
    .samples_counted (samples_counted),
    .count_saturated (count_saturated)
  );

endmodule

/* bench/complex_average_power_meter_test.sv */
// testbench for the complex average power meter: directed and random sample streams
module complex_average_power_meter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import capm_pkg::*;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct {
    logic [OUT_WIDTH-1:0] avg;
    logic [OUT_WIDTH-1:0] count;
    logic                 saturated;
  } power_report_t;

  localparam logic [IN_WIDTH-1:0] MOST_NEG = {1'b1, {(IN_WIDTH-1){1'b0}}};
  localparam logic [IN_WIDTH-1:0] MOST_POS = {1'b0, {(IN_WIDTH-1){1'b1}}};
  localparam int DRAIN_CYCLES = 100;
  localparam logic [ADDR_WIDTH-1:0] MEMORY_ADDR = ADDR_WIDTH'(REG_MEMORY_IDX * 4);

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_WIDTH-1:0] paddr = '0;
  logic [DATA_WIDTH-1:0] pwdata = '0;
  logic [DATA_WIDTH-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [IN_WIDTH-1:0]   sample_i = '0;
  logic [IN_WIDTH-1:0]   sample_q = '0;
  logic                  last_in_block = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [OUT_WIDTH-1:0]  avg_power;
  logic [OUT_WIDTH-1:0]  samples_counted;
  logic                  count_saturated;

  // predictor state
  logic [SUM_WIDTH-1:0]   acc_energy = '0;
  logic [COUNT_WIDTH-1:0] acc_count = '0;
  logic                   new_block = 1'b1;
  logic                   acc_saturated = 1'b0;
  logic                   memory_on = 1'b1;

  power_report_t avg_due[$];
  int            error_count = 0;
  idle_mode_t    idle_mode = IDLE_NONE;
  bit            calm_stretch = 1'b0;

  complex_average_power_meter u_top (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .sample_i        (sample_i),
    .sample_q        (sample_q),
    .last_in_block   (last_in_block),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .avg_power       (avg_power),
    .samples_counted (samples_counted),
    .count_saturated (count_saturated)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  function automatic int sender_idle_pct();
    if (calm_stretch) return 0;
    case (idle_mode)
      IDLE_SENDER: return 48;
      IDLE_BOTH:   return 23;
      default:     return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct();
    if (calm_stretch) return 0;
    case (idle_mode)
      IDLE_RECEIVER: return 48;
      IDLE_BOTH:     return 23;
      default:       return 0;
    endcase
  endfunction

  // fold one accepted sample into the running totals, queue a report at block end
  task automatic fold_sample(input logic [IN_WIDTH-1:0] i, input logic [IN_WIDTH-1:0] q,
                             input logic last);
    longint               si;
    longint               sq;
    logic [SUM_WIDTH-1:0] e;
    logic [SUM_WIDTH-1:0] quotient;
    power_report_t        rep;
    si = $signed(i);
    sq = $signed(q);
    if (new_block) begin
      if (!memory_on) begin
        acc_energy = '0;
        acc_count = '0;
        acc_saturated = 1'b0;
      end
      new_block = 1'b0;
    end
    e = SUM_WIDTH'(si * si + sq * sq);
    if (acc_count != {COUNT_WIDTH{1'b1}}) begin
      if (acc_energy > ~e) acc_energy = '1;
      else acc_energy = acc_energy + e;
      acc_count = acc_count + 1'b1;
    end else begin
      acc_saturated = 1'b1;
    end
    if (last) begin
      new_block = 1'b1;
      quotient = (acc_count != 0) ? acc_energy / SUM_WIDTH'(acc_count) : '0;
      if (quotient > SUM_WIDTH'({OUT_WIDTH{1'b1}})) quotient = SUM_WIDTH'({OUT_WIDTH{1'b1}});
      rep.avg = quotient[OUT_WIDTH-1:0];
      rep.count = OUT_WIDTH'(acc_count);
      rep.saturated = acc_saturated;
      avg_due.push_back(rep);
    end
  endtask

  task automatic send_sample(input logic [IN_WIDTH-1:0] i, input logic [IN_WIDTH-1:0] q,
                             input logic last);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct() && gap < 20) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      sample_i <= IN_WIDTH'($urandom());
      sample_q <= IN_WIDTH'($urandom());
      last_in_block <= 1'($urandom_range(1));
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    sample_i <= i;
    sample_q <= q;
    last_in_block <= last;
    do @(posedge clk); while (in_stall);
    fold_sample(i, q, last);
  endtask

  // lower valid and wait until every block result is in and the divider is quiet
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (avg_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_memory_mode(input logic on);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MEMORY_ADDR;
    pwdata <= DATA_WIDTH'(on);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    memory_on = on;
    // read back through a second transfer
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== DATA_WIDTH'(on))
      report_mismatch($sformatf("memory register read %0h, wrote %0b", prdata, on));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [IN_WIDTH-1:0] pick_component();
    case ($urandom_range(9))
      0:       return MOST_NEG;
      1:       return MOST_POS;
      2:       return '0;
      3:       return IN_WIDTH'(int'($urandom_range(16)) - 8);
      default: return IN_WIDTH'($urandom());
    endcase
  endfunction

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct());
  end

  always @(posedge clk) begin
    power_report_t want;
    if (!rst && out_valid && !out_stall) begin
      if (avg_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result avg %0d count %0d", avg_power,
                                  samples_counted));
      end else begin
        want = avg_due.pop_front();
        if (avg_power !== want.avg)
          report_mismatch($sformatf("avg_power expected %0d, got %0d", want.avg, avg_power));
        if (samples_counted !== want.count)
          report_mismatch($sformatf("samples_counted expected %0d, got %0d", want.count,
                                    samples_counted));
        if (count_saturated !== want.saturated)
          report_mismatch($sformatf("count_saturated expected %0b, got %0b", want.saturated,
                                    count_saturated));
      end
    end
  end

  // memory is on after reset: totals run across blocks
  task automatic test_extreme_samples();
    send_sample(MOST_NEG, MOST_NEG, 1'b1);
    send_sample(MOST_POS, MOST_POS, 1'b0);
    send_sample('0, '0, 1'b0);
    send_sample('1, IN_WIDTH'(1), 1'b1);
    send_sample(MOST_NEG, MOST_POS, 1'b1);
    send_sample('0, '0, 1'b1);
    wait_idle();
  endtask

  task automatic test_memory_off_restart();
    set_memory_mode(1'b0);
    send_sample('0, '0, 1'b1);
    send_sample(MOST_NEG, '0, 1'b1);
    send_sample(MOST_POS, MOST_NEG, 1'b0);
    send_sample(IN_WIDTH'(1), '1, 1'b1);
    send_sample(MOST_NEG, MOST_NEG, 1'b0);
    send_sample(IN_WIDTH'(3), IN_WIDTH'(4), 1'b1);
    wait_idle();
  endtask

  // a write in the middle of a block only counts from the next block start
  task automatic test_write_mid_block();
    send_sample(IN_WIDTH'(100), IN_WIDTH'(200), 1'b0);
    wait_idle();
    set_memory_mode(1'b1);
    send_sample(IN_WIDTH'(5), IN_WIDTH'(5), 1'b1);
    send_sample(IN_WIDTH'(7), IN_WIDTH'(-7), 1'b1);
    send_sample(MOST_POS, '0, 1'b0);
    wait_idle();
    set_memory_mode(1'b0);
    send_sample(IN_WIDTH'(-2), IN_WIDTH'(9), 1'b1);
    send_sample(IN_WIDTH'(11), IN_WIDTH'(0), 1'b1);
    wait_idle();
  endtask

  task automatic run_random_phase(input idle_mode_t mode, input logic mem, input int items);
    int sent;
    int len;
    set_memory_mode(mem);
    idle_mode = mode;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      calm_stretch = ($urandom_range(4) == 0);
      for (int k = 1; k <= len && sent < items; k++) begin
        send_sample(pick_component(), pick_component(), k == len);
        sent++;
      end
    end
    calm_stretch = 1'b0;
    wait_idle();
    idle_mode = IDLE_NONE;
  endtask

  task automatic test_random_streams();
    idle_mode_t modes[4];
    modes = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};
    foreach (modes[m]) begin
      run_random_phase(modes[m], 1'b1, 56);
      run_random_phase(modes[m], 1'b0, 56);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_extreme_samples();
    test_memory_off_restart();
    test_write_mid_block();
    test_random_streams();
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
